// ===== rtl/core/lrf_pkg.sv =====
// Shared types and constants of the line rasterizer frame buffer.
`timescale 1ns / 1ps
`default_nettype none
package lrf_pkg;

    // Fixed field widths of the transactions and registers
    localparam int COORD_W  = 6;
    localparam int COLOUR_W = 8;
    localparam int WIN_W    = 7;
    localparam int CFG_IDX_W = 1;

    // Default frame geometry
    localparam int DEF_FRAME_WIDTH  = 64;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int DEF_PIXEL_BITS   = 8;

    // Window registers after reset
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    // Operation codes of the func field
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 1'b1;

    // Result status codes
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Control sequencer states
    typedef enum logic [2:0] {
        LRF_CLEAR,
        LRF_IDLE,
        LRF_DRAW,
        LRF_READ,
        LRF_DONE
    } lrf_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lrf_cmd_if.sv =====
// Command channel carrying draw and read transactions into the block.
`timescale 1ns / 1ps
`default_nettype none
interface lrf_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [lrf_pkg::COORD_W-1:0]     start_x;
    logic [lrf_pkg::COORD_W-1:0]     start_y;
    logic [lrf_pkg::COORD_W-1:0]     end_x;
    logic [lrf_pkg::COORD_W-1:0]     end_y;
    logic [lrf_pkg::COLOUR_W-1:0]    colour;

    modport source (
        output valid, func, start_x, start_y, end_x, end_y, colour,
        input  ready
    );

    modport sink (
        input  valid, func, start_x, start_y, end_x, end_y, colour,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/lrf_rsp_if.sv =====
// Response channel carrying one result transaction per command.
`timescale 1ns / 1ps
`default_nettype none
interface lrf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [lrf_pkg::COLOUR_W-1:0]    pixel_value;

    modport source (
        output valid, status, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, status, pixel_value,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/lrf_frame_mem.sv =====
// Frame store: single write port, single read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lrf_frame_mem #(
    parameter int DEPTH  = lrf_pkg::DEF_FRAME_WIDTH * lrf_pkg::DEF_FRAME_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = lrf_pkg::DEF_PIXEL_BITS
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write one pixel
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one pixel; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/line_rasterizer_framebuffer_unit.sv =====
// Top level of the line rasterizer with its frame store and control sequencer.
`timescale 1ns / 1ps
`default_nettype none
// The block holds a FRAME_WIDTH x FRAME_HEIGHT frame store of PIXEL_BITS-wide
// pixels in one synchronous memory and answers every command transaction with
// exactly one response. After reset a clearing pass writes zero to every pixel,
// one per cycle, so the block takes no command until the pass has written the
// last pixel; configuration writes are taken meanwhile.
// A draw inside the window passes through DRAW, setting one pixel per cycle
// through the single memory write port as the Bresenham stepper walks the line,
// then DONE; a read passes through READ, which issues the memory read, then DONE,
// and a rejected command goes straight to DONE. The response sits in an
// output register, so the next command is accepted while it waits.
module line_rasterizer_framebuffer_unit #(
    parameter int FRAME_WIDTH  = lrf_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lrf_pkg::DEF_FRAME_HEIGHT,
    parameter int PIXEL_BITS   = lrf_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lrf_cmd_if.sink                              cmd,
    lrf_rsp_if.source                            rsp,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lrf_pkg::WIN_W-1:0]       cfg_wdata
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Control state
    lrf_pkg::lrf_state_t state_reg, state_next;
    logic [ADDR_W-1:0]              clr_addr_reg, clr_addr_next;
    logic [lrf_pkg::WIN_W-1:0]      win_w_reg, win_h_reg;
    logic                           out_valid_reg;
    logic                           out_load;

    // Per-command working registers
    logic [lrf_pkg::COORD_W-1:0]    cur_x_reg, cur_x_next;
    logic [lrf_pkg::COORD_W-1:0]    cur_y_reg, cur_y_next;
    logic [lrf_pkg::COORD_W-1:0]    end_x_reg, end_x_next;
    logic [lrf_pkg::COORD_W-1:0]    end_y_reg, end_y_next;
    logic [lrf_pkg::COORD_W:0]      dx_reg, dx_next;
    logic [lrf_pkg::COORD_W:0]      dy_reg, dy_next;
    logic signed [9:0]              err_reg, err_next;
    logic                           x_dec_reg, x_dec_next;
    logic                           y_dec_reg, y_dec_next;
    logic [PIXEL_BITS-1:0]          colour_reg, colour_next;
    logic                           status_reg, status_next;
    logic                           read_reg, read_next;

    // Response payload registers
    logic                           out_status_reg;
    logic [lrf_pkg::COLOUR_W-1:0]   out_pixel_reg;

    // Memory port signals
    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [PIXEL_BITS-1:0]          mem_wdata;
    logic                           mem_re;
    logic [ADDR_W-1:0]              pt_addr;
    logic [PIXEL_BITS-1:0]          mem_rdata;

    // Command decode
    logic                           accept;
    logic                           start_in, end_in, reject;
    logic [lrf_pkg::COORD_W:0]      in_dx, in_dy;

    // Stepper arithmetic
    logic signed [10:0]             dx_s, dy_s, e2, err_ext, err_sum;
    logic                           step_x, step_y, at_end;

    // Window checks: the limit is the smaller of the register and the frame
    assign start_in = ({1'b0, cmd.start_x} < win_w_reg)
                   && ({1'b0, cmd.start_y} < win_h_reg)
                   && (32'(cmd.start_x) < 32'(FRAME_WIDTH))
                   && (32'(cmd.start_y) < 32'(FRAME_HEIGHT));
    assign end_in   = ({1'b0, cmd.end_x} < win_w_reg)
                   && ({1'b0, cmd.end_y} < win_h_reg)
                   && (32'(cmd.end_x) < 32'(FRAME_WIDTH))
                   && (32'(cmd.end_y) < 32'(FRAME_HEIGHT));
    assign reject   = !start_in || ((cmd.func == lrf_pkg::FUNC_DRAW) && !end_in);

    assign cmd.ready = (state_reg == lrf_pkg::LRF_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // Line extents of the incoming command
    assign in_dx = (cmd.end_x > cmd.start_x) ? {1'b0, cmd.end_x - cmd.start_x}
                                             : {1'b0, cmd.start_x - cmd.end_x};
    assign in_dy = (cmd.end_y > cmd.start_y) ? {1'b0, cmd.end_y - cmd.start_y}
                                             : {1'b0, cmd.start_y - cmd.end_y};

    // Bresenham error comparison for the current pixel
    assign dx_s    = $signed({4'b0, dx_reg});
    assign dy_s    = $signed({4'b0, dy_reg});
    assign e2      = $signed({err_reg, 1'b0});
    assign err_ext = {err_reg[9], err_reg};
    assign step_x  = (e2 >= -dy_s);
    assign step_y  = (e2 <= dx_s);
    assign err_sum = err_ext - (step_x ? dy_s : 11'sd0) + (step_y ? dx_s : 11'sd0);
    assign at_end  = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);

    // Row-major address of the current point
    assign pt_addr = ADDR_W'(32'(cur_y_reg) * 32'(FRAME_WIDTH) + 32'(cur_x_reg));

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        end_x_next    = end_x_reg;
        end_y_next    = end_y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        err_next      = err_reg;
        x_dec_next    = x_dec_reg;
        y_dec_next    = y_dec_reg;
        colour_next   = colour_reg;
        status_next   = status_reg;
        read_next     = read_reg;
        mem_we        = 1'b0;
        mem_waddr     = pt_addr;
        mem_wdata     = colour_reg;
        mem_re        = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            lrf_pkg::LRF_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = lrf_pkg::LRF_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            lrf_pkg::LRF_IDLE:
            begin
                if (accept)
                begin
                    cur_x_next  = cmd.start_x;
                    cur_y_next  = cmd.start_y;
                    end_x_next  = cmd.end_x;
                    end_y_next  = cmd.end_y;
                    dx_next     = in_dx;
                    dy_next     = in_dy;
                    err_next    = $signed({3'b0, in_dx}) - $signed({3'b0, in_dy});
                    x_dec_next  = !(cmd.start_x < cmd.end_x);
                    y_dec_next  = !(cmd.start_y < cmd.end_y);
                    colour_next = PIXEL_BITS'(cmd.colour);
                    status_next = reject ? lrf_pkg::STATUS_REJECT : lrf_pkg::STATUS_DONE;
                    read_next   = (cmd.func == lrf_pkg::FUNC_READ);
                    if (reject)
                    begin
                        state_next = lrf_pkg::LRF_DONE;
                    end
                    else if (cmd.func == lrf_pkg::FUNC_READ)
                    begin
                        state_next = lrf_pkg::LRF_READ;
                    end
                    else
                    begin
                        state_next = lrf_pkg::LRF_DRAW;
                    end
                end
            end

            lrf_pkg::LRF_DRAW:
            begin
                // Plot the current pixel, then advance toward the end point
                mem_we = 1'b1;
                if (at_end)
                begin
                    state_next = lrf_pkg::LRF_DONE;
                end
                else
                begin
                    err_next = err_sum[9:0];
                    if (step_x)
                    begin
                        cur_x_next = x_dec_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    end
                    if (step_y)
                    begin
                        cur_y_next = y_dec_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    end
                end
            end

            lrf_pkg::LRF_READ:
            begin
                mem_re     = 1'b1;
                state_next = lrf_pkg::LRF_DONE;
            end

            lrf_pkg::LRF_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = lrf_pkg::LRF_IDLE;
                end
            end

            default:
            begin
                state_next = lrf_pkg::LRF_IDLE;
            end
        endcase
    end

    // Hold the sequencer state and clearing pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lrf_pkg::LRF_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Take configuration writes; an unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg <= lrf_pkg::WIN_RESET;
            win_h_reg <= lrf_pkg::WIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lrf_pkg::CFG_WINDOW_WIDTH:  win_w_reg <= cfg_wdata;
                lrf_pkg::CFG_WINDOW_HEIGHT: win_h_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        end_x_reg  <= end_x_next;
        end_y_reg  <= end_y_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        err_reg    <= err_next;
        x_dec_reg  <= x_dec_next;
        y_dec_reg  <= y_dec_next;
        colour_reg <= colour_next;
        status_reg <= status_next;
        read_reg   <= read_next;
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload; draws and rejects return zero
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_pixel_reg  <= (read_reg && (status_reg == lrf_pkg::STATUS_DONE))
                            ? lrf_pkg::COLOUR_W'(mem_rdata) : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.pixel_value = out_pixel_reg;

    lrf_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIXEL_BITS)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (pt_addr),
        .rdata (mem_rdata)
    );

    // The store is written only by the clearing pass or the line stepper
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == lrf_pkg::LRF_CLEAR || state_reg == lrf_pkg::LRF_DRAW))
        else $error("frame store written outside clear or draw");

    // A rejected response never carries pixel data
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == lrf_pkg::STATUS_REJECT) |-> (rsp.pixel_value == '0))
        else $error("rejected response with nonzero pixel");

    // An accepted in-window read goes to the memory read next
    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.func == lrf_pkg::FUNC_READ && !reject)
        |=> (state_reg == lrf_pkg::LRF_READ))
        else $error("accepted read did not issue a memory read");

    // A pending result is not overwritten while the response stalls
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the line rasterizer frame buffer unit.
`timescale 1ns / 1ps
module tb;

    localparam int FRAME_W     = lrf_pkg::DEF_FRAME_WIDTH;
    localparam int FRAME_H     = lrf_pkg::DEF_FRAME_HEIGHT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 80;
    localparam int HOLD_AT     = 80;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic                         func;
        logic [lrf_pkg::COORD_W-1:0]  start_x;
        logic [lrf_pkg::COORD_W-1:0]  start_y;
        logic [lrf_pkg::COORD_W-1:0]  end_x;
        logic [lrf_pkg::COORD_W-1:0]  end_y;
        logic [lrf_pkg::COLOUR_W-1:0] colour;
    } raster_cmd_t;

    typedef struct packed {
        logic                         status;
        logic [lrf_pkg::COLOUR_W-1:0] pixel_value;
    } raster_rsp_t;

    // Shadow copy of the frame store and window; queues the answer to each command
    class frame_shadow;
        logic [lrf_pkg::COLOUR_W-1:0] pixels [FRAME_W * FRAME_H];
        int unsigned         win_w;
        int unsigned         win_h;
        raster_rsp_t         due_responses [$];
        int unsigned         n_draw;
        int unsigned         n_read;
        int unsigned         n_reject;
        int unsigned         n_fail;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = '0;
            end
            win_w = 32'(lrf_pkg::WIN_RESET);
            win_h = 32'(lrf_pkg::WIN_RESET);
            n_draw = 0;
            n_read = 0;
            n_reject = 0;
            n_fail = 0;
        endfunction

        function void set_window(logic [lrf_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
            if (idx == lrf_pkg::CFG_WINDOW_WIDTH)
            begin
                win_w = value & 32'h7F;
            end
            else if (idx == lrf_pkg::CFG_WINDOW_HEIGHT)
            begin
                win_h = value & 32'h7F;
            end
        endfunction

        // A window wider than the frame is clipped to the frame
        function bit fits(int x, int y);
            int lx;
            int ly;
            lx = (win_w < FRAME_W) ? win_w : FRAME_W;
            ly = (win_h < FRAME_H) ? win_h : FRAME_H;
            return (x < lx) && (y < ly);
        endfunction

        // Walk the line with the usual Bresenham error term, both ends included
        function void plot_line(int x0, int y0, int x1, int y1,
                                logic [lrf_pkg::COLOUR_W-1:0] v);
            int dx;
            int dy;
            int sx;
            int sy;
            int err;
            int e2;
            int g;
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            for (g = 0; g <= 2 * (FRAME_W + FRAME_H); g++)
            begin
                if (x0 >= 0 && y0 >= 0 && x0 < FRAME_W && y0 < FRAME_H)
                begin
                    pixels[y0 * FRAME_W + x0] = v;
                end
                if (x0 == x1 && y0 == y1)
                begin
                    break;
                end
                e2 = 2 * err;
                if (e2 >= -dy)
                begin
                    err -= dy;
                    x0 += sx;
                end
                if (e2 <= dx)
                begin
                    err += dx;
                    y0 += sy;
                end
            end
        endfunction

        // Apply an accepted command and queue the response it must produce
        function void apply_command(raster_cmd_t c);
            raster_rsp_t r;
            r.status = lrf_pkg::STATUS_DONE;
            r.pixel_value = '0;
            if (c.func == lrf_pkg::FUNC_READ)
            begin
                n_read++;
                if (!fits(int'(c.start_x), int'(c.start_y)))
                begin
                    r.status = lrf_pkg::STATUS_REJECT;
                end
                else
                begin
                    r.pixel_value = pixels[int'(c.start_y) * FRAME_W + int'(c.start_x)];
                end
            end
            else
            begin
                n_draw++;
                if (!fits(int'(c.start_x), int'(c.start_y)) ||
                    !fits(int'(c.end_x), int'(c.end_y)))
                begin
                    r.status = lrf_pkg::STATUS_REJECT;
                end
                else
                begin
                    plot_line(int'(c.start_x), int'(c.start_y), int'(c.end_x),
                              int'(c.end_y), c.colour);
                end
            end
            if (r.status == lrf_pkg::STATUS_REJECT)
            begin
                n_reject++;
            end
            due_responses.push_back(r);
        endfunction

        // Compare a response transaction with the oldest queued answer
        function void match_response(logic status, logic [lrf_pkg::COLOUR_W-1:0] pix);
            raster_rsp_t want;
            if (due_responses.size() == 0)
            begin
                $error("response with nothing outstanding: status %0d pixel_value %0d",
                       status, pix);
                n_fail++;
                return;
            end
            want = due_responses.pop_front();
            if (status !== want.status)
            begin
                $error("status mismatch: expected %0d actual %0d", want.status, status);
                n_fail++;
            end
            if (pix !== want.pixel_value)
            begin
                $error("pixel_value mismatch: expected %0d actual %0d",
                       want.pixel_value, pix);
                n_fail++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [lrf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lrf_pkg::WIN_W-1:0]     cfg_wdata;
    frame_shadow          shadow;
    int unsigned          cycles = 0;
    int unsigned          settings_used = 0;
    int unsigned          tx_count = 0;
    int unsigned          tx_style = 0;

    lrf_cmd_if cmd_ch ();
    lrf_rsp_if rsp_ch ();

    line_rasterizer_framebuffer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle styles: none, full range, short gaps
    function automatic int unsigned pick_idle(int unsigned style);
        if (style == 0)
        begin
            return 0;
        end
        else if (style == 1)
        begin
            return $urandom_range(0, 18);
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic raster_cmd_t mk(logic func, int sx, int sy, int ex, int ey, int col);
        raster_cmd_t c;
        c.func = func;
        c.start_x = lrf_pkg::COORD_W'(sx);
        c.start_y = lrf_pkg::COORD_W'(sy);
        c.end_x = lrf_pkg::COORD_W'(ex);
        c.end_y = lrf_pkg::COORD_W'(ey);
        c.colour = lrf_pkg::COLOUR_W'(col);
        return c;
    endfunction

    // Mostly in-window draws and reads of every shape, the rest raw noise
    function automatic raster_cmd_t make_item(int unsigned w, int unsigned h);
        raster_cmd_t c;
        int unsigned lx;
        int unsigned ly;
        int unsigned r;
        int unsigned shape;
        c.func = 1'($urandom);
        c.start_x = lrf_pkg::COORD_W'($urandom);
        c.start_y = lrf_pkg::COORD_W'($urandom);
        c.end_x = lrf_pkg::COORD_W'($urandom);
        c.end_y = lrf_pkg::COORD_W'($urandom);
        c.colour = lrf_pkg::COLOUR_W'($urandom);
        lx = (w < FRAME_W) ? w : FRAME_W;
        ly = (h < FRAME_H) ? h : FRAME_H;
        r = $urandom_range(0, 99);
        if (r < 12 || lx == 0 || ly == 0)
        begin
            return c;
        end
        c.func = (r < 56) ? lrf_pkg::FUNC_DRAW : lrf_pkg::FUNC_READ;
        c.start_x = lrf_pkg::COORD_W'($urandom_range(0, lx - 1));
        c.start_y = lrf_pkg::COORD_W'($urandom_range(0, ly - 1));
        c.end_x = lrf_pkg::COORD_W'($urandom_range(0, lx - 1));
        c.end_y = lrf_pkg::COORD_W'($urandom_range(0, ly - 1));
        shape = $urandom_range(0, 5);
        if (shape == 0)
        begin
            c.end_x = c.start_x;
            c.end_y = c.start_y;
        end
        else if (shape == 1)
        begin
            c.end_y = c.start_y;
        end
        else if (shape == 2)
        begin
            c.end_x = c.start_x;
        end
        return c;
    endfunction

    // Offer one command after a random gap; keep valid high when there is none
    task automatic send_cmd(input raster_cmd_t c);
        int unsigned idle;
        if (tx_count % 24 == 0)
        begin
            tx_style = $urandom_range(0, 2);
        end
        idle = pick_idle(tx_style);
        tx_count++;
        if (idle > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= c.func;
        cmd_ch.start_x <= c.start_x;
        cmd_ch.start_y <= c.start_y;
        cmd_ch.end_x <= c.end_x;
        cmd_ch.end_y <= c.end_y;
        cmd_ch.colour <= c.colour;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        shadow.apply_command(c);
    endtask

    // Drop valid and hold until every response has come back
    task automatic drain;
        cmd_ch.valid <= 1'b0;
        while (shadow.due_responses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_window(input int unsigned w, input int unsigned h);
        cfg_wr_en <= 1'b1;
        cfg_index <= lrf_pkg::CFG_WINDOW_WIDTH;
        cfg_wdata <= lrf_pkg::WIN_W'(w);
        @(posedge clk);
        shadow.set_window(lrf_pkg::CFG_WINDOW_WIDTH, w);
        cfg_index <= lrf_pkg::CFG_WINDOW_HEIGHT;
        cfg_wdata <= lrf_pkg::WIN_W'(h);
        @(posedge clk);
        shadow.set_window(lrf_pkg::CFG_WINDOW_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Response side: random stalls plus one long hold-off that backs up the block
    initial
    begin
        int unsigned stall;
        int unsigned style;
        int unsigned taken;
        taken = 0;
        style = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 24 == 0)
            begin
                style = $urandom_range(0, 2);
            end
            stall = (taken == HOLD_AT) ? HOLD_CYCLES : pick_idle(style);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            shadow.match_response(rsp_ch.status, rsp_ch.pixel_value);
            taken++;
        end
    end

    // Command side: reset, directed cases, then random phases under several windows
    initial
    begin
        raster_cmd_t directed [$];
        int unsigned w;
        int unsigned h;
        int unsigned n;
        shadow = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= lrf_pkg::CFG_WINDOW_WIDTH;
        cfg_wdata <= lrf_pkg::WIN_RESET;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= lrf_pkg::FUNC_DRAW;
        cmd_ch.start_x <= '0;
        cmd_ch.start_y <= '0;
        cmd_ch.end_x <= '0;
        cmd_ch.end_y <= '0;
        cmd_ch.colour <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Full window: cleared store, point, horizontal, vertical, diagonal, steep, shallow
        program_window(64, 64);
        directed.push_back(mk(lrf_pkg::FUNC_READ, 0, 0, 63, 63, 255));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 63, 63, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 5, 5, 5, 5, 255));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 5, 5, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 0, 10, 63, 10, 165));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 63, 10, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 20, 63, 20, 0, 90));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 20, 0, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 0, 0, 63, 63, 1));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 31, 31, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 10, 0, 13, 63, 128));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 63, 40, 0, 37, 127));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 0, 37, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 5, 5, 5, 5, 0));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 5, 5, 63, 63, 255));
        foreach (directed[i])
        begin
            send_cmd(directed[i]);
        end
        drain();

        // Narrow window: edge-of-window draw, then rejected draws and reads
        program_window(32, 16);
        directed.delete();
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 31, 15, 0, 0, 60));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 31, 15, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 31, 15, 32, 0, 77));
        directed.push_back(mk(lrf_pkg::FUNC_DRAW, 0, 16, 0, 0, 77));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 0, 16, 0, 0, 0));
        directed.push_back(mk(lrf_pkg::FUNC_READ, 32, 0, 0, 0, 0));
        foreach (directed[i])
        begin
            send_cmd(directed[i]);
        end
        drain();

        // Random phases; the degenerate windows get fewer commands
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: begin w = 127; h = 127; n = 170; end
                1: begin w = 1; h = 1; n = 40; end
                2: begin w = 0; h = 0; n = 30; end
                3: begin w = 64; h = 1; n = 60; end
                4: begin w = 1; h = 64; n = 60; end
                5: begin w = 0; h = 64; n = 30; end
                6: begin w = 64; h = 0; n = 30; end
                default:
                begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 127)
                                                    : $urandom_range(2, 64);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 127)
                                                    : $urandom_range(2, 64);
                    n = 160;
                end
            endcase
            program_window(w, h);
            repeat (n) send_cmd(make_item(w, h));
            drain();
        end

        // Let any stray response show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d draws and %0d reads, %0d of them rejected, under %0d windows.",
                 shadow.n_draw, shadow.n_read, shadow.n_reject, settings_used);
        if (shadow.n_fail == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
